[sv/shamh_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package shamh_pkg;

   // Buffer fill position at which the length field starts, and the last byte slot.
   localparam logic [5:0] FILL_LEN_POS = 6'd56;
   localparam logic [5:0] FILL_LAST    = 6'd63;
   localparam logic [5:0] ROUND_LAST   = 6'd63;
   localparam logic [7:0] PAD_BYTE     = 8'h80;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COMPRESS,
      ST_UPDATE,
      ST_PAD_ONE,
      ST_PAD_ZERO,
      ST_PAD_LEN,
      ST_FINISH
   } state_type;

   // Which block is being compressed: plain message data, the first of two
   // padding blocks, or the final block that carries the length.
   typedef enum logic [1:0] {
      PH_DATA,
      PH_PAD,
      PH_LAST
   } phase_type;

   typedef enum logic [1:0] {
      SRC_DATA,
      SRC_PAD80,
      SRC_ZERO,
      SRC_LEN
   } src_type;

   typedef struct packed {
      logic       shift_en;
      src_type    shift_sel;
      logic       count_en;
      logic       load_vars;
      logic       round_en;
      logic [5:0] round_idx;
      logic       update_chain;
      logic       finish;
   } cmd_type;

   typedef struct packed {
      logic out_busy;
   } status_type;

   function automatic logic [31:0] init_word(input logic [2:0] idx);
      logic [31:0] w;
      case (idx)
         3'd0: w = 32'h6a09e667;
         3'd1: w = 32'hbb67ae85;
         3'd2: w = 32'h3c6ef372;
         3'd3: w = 32'ha54ff53a;
         3'd4: w = 32'h510e527f;
         3'd5: w = 32'h9b05688c;
         3'd6: w = 32'h1f83d9ab;
         3'd7: w = 32'h5be0cd19;
         default: w = 32'h0;
      endcase
      return w;
   endfunction

   function automatic logic [31:0] round_k(input logic [5:0] idx);
      logic [31:0] k;
      case (idx)
         6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

endpackage

`default_nettype wire

[sv/shamh_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module shamh_ctrl
   import shamh_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output      logic       req_tready,
   input  wire logic       req_tuser,
   input  wire logic       req_tlast,
   input  wire status_type status,
   output      cmd_type    cmd
);

   state_type  state_ff, state_in;
   phase_type  phase_ff, phase_in;
   logic [5:0] fill_ff, fill_in;
   logic [5:0] round_ff, round_in;
   logic       last_ff, last_in;
   logic       accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_DATA;
         fill_ff  <= '0;
         round_ff <= '0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         fill_ff  <= fill_in;
         round_ff <= round_in;
         last_ff  <= last_in;
      end
   end

   // Next state and counters.
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      fill_in  = fill_ff;
      round_in = round_ff;
      last_in  = last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser) begin
                  fill_in = fill_ff + 6'd1;
                  if (fill_ff == FILL_LAST) begin
                     state_in = ST_COMPRESS;
                     phase_in = PH_DATA;
                     last_in  = req_tlast;
                  end else if (req_tlast) begin
                     state_in = ST_PAD_ONE;
                  end
               end else if (req_tlast) begin
                  state_in = ST_PAD_ONE;
               end
            end
         end
         ST_COMPRESS: begin
            round_in = round_ff + 6'd1;
            if (round_ff == ROUND_LAST) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            case (phase_ff)
               PH_DATA: begin
                  last_in  = 1'b0;
                  state_in = last_ff ? ST_PAD_ONE : ST_IDLE;
               end
               PH_PAD:  state_in = ST_PAD_ZERO;
               PH_LAST: state_in = ST_FINISH;
               default: state_in = ST_IDLE;
            endcase
         end
         ST_PAD_ONE: begin
            fill_in  = fill_ff + 6'd1;
            phase_in = PH_PAD;
            state_in = (fill_ff == FILL_LAST) ? ST_COMPRESS : ST_PAD_ZERO;
         end
         ST_PAD_ZERO: begin
            if (fill_ff == FILL_LEN_POS) begin
               state_in = ST_PAD_LEN;
            end else begin
               fill_in = fill_ff + 6'd1;
               if (fill_ff == FILL_LAST) begin
                  state_in = ST_COMPRESS;
               end
            end
         end
         ST_PAD_LEN: begin
            fill_in = fill_ff + 6'd1;
            if (fill_ff == FILL_LAST) begin
               state_in = ST_COMPRESS;
               phase_in = PH_LAST;
            end
         end
         ST_FINISH: begin
            if (!status.out_busy) begin
               state_in = ST_IDLE;
               phase_in = PH_DATA;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd              = '0;
      cmd.shift_sel    = SRC_DATA;
      cmd.round_idx    = round_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.shift_en  = accept && req_tuser;
            cmd.count_en  = accept && req_tuser;
            cmd.load_vars = accept && req_tuser && (fill_ff == FILL_LAST);
         end
         ST_COMPRESS: cmd.round_en = 1'b1;
         ST_UPDATE:   cmd.update_chain = 1'b1;
         ST_PAD_ONE: begin
            cmd.shift_en  = 1'b1;
            cmd.shift_sel = SRC_PAD80;
            cmd.load_vars = (fill_ff == FILL_LAST);
         end
         ST_PAD_ZERO: begin
            cmd.shift_en  = (fill_ff != FILL_LEN_POS);
            cmd.shift_sel = SRC_ZERO;
            cmd.load_vars = (fill_ff == FILL_LAST);
         end
         ST_PAD_LEN: begin
            cmd.shift_en  = 1'b1;
            cmd.shift_sel = SRC_LEN;
            cmd.load_vars = (fill_ff == FILL_LAST);
         end
         ST_FINISH: cmd.finish = !status.out_busy;
         default: cmd = '0;
      endcase
   end

   // The round counter only runs inside a compression and wraps back to zero.
   a_round_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_COMPRESS) |-> (round_ff == 6'd0))
      else $error("round counter nonzero outside compression");

   // A compression always starts on a completely filled buffer.
   a_compress_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMPRESS) |-> (fill_ff == 6'd0))
      else $error("compression with partial buffer");

   // The length field always lands in the last eight byte slots.
   a_len_pos: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PAD_LEN && $past(state_ff) == ST_PAD_ZERO)
      |-> (fill_ff == FILL_LEN_POS))
      else $error("length field misplaced");

   a_round_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMPRESS && round_ff == ROUND_LAST) |=> (state_ff == ST_UPDATE))
      else $error("compression did not end after the last round");

endmodule

`default_nettype wire

[sv/shamh_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module shamh_datapath
   import shamh_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cmd_type      cmd,
   output      status_type   status,
   input  wire logic [7:0]   req_tdata,
   output      logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   output      logic [255:0] rsp_tdata
);

   // The block buffer doubles as the schedule window: bytes shift in at the
   // low end, and during rounds the oldest word leaves at the top.
   logic [511:0] buf_ff;
   logic [31:0]  chain_ff [8];
   logic [31:0]  var_ff [8];
   logic [63:0]  bitcnt_ff;
   logic [255:0] out_ff;
   logic         out_valid_ff;

   logic [7:0]   shift_byte;
   logic [31:0]  w0, w1, w9, w14, new_w;
   logic [31:0]  t1, t2, ch, maj;

   always_comb begin
      case (cmd.shift_sel)
         SRC_DATA:  shift_byte = req_tdata;
         SRC_PAD80: shift_byte = PAD_BYTE;
         SRC_ZERO:  shift_byte = 8'h00;
         SRC_LEN:   shift_byte = bitcnt_ff[63:56];
         default:   shift_byte = 8'h00;
      endcase
   end

   assign w0    = buf_ff[511:480];
   assign w1    = buf_ff[479:448];
   assign w9    = buf_ff[223:192];
   assign w14   = buf_ff[63:32];
   assign new_w = small_sigma1(w14) + w9 + small_sigma0(w1) + w0;

   assign ch  = (var_ff[4] & var_ff[5]) ^ (~var_ff[4] & var_ff[6]);
   assign maj = (var_ff[0] & var_ff[1]) ^ (var_ff[0] & var_ff[2]) ^ (var_ff[1] & var_ff[2]);
   assign t1  = var_ff[7] + big_sigma1(var_ff[4]) + ch + round_k(cmd.round_idx) + w0;
   assign t2  = big_sigma0(var_ff[0]) + maj;

   always_ff @(posedge clock) begin
      if (cmd.shift_en) begin
         buf_ff <= {buf_ff[503:0], shift_byte};
      end else if (cmd.round_en) begin
         buf_ff <= {buf_ff[479:0], new_w};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_vars) begin
         for (int i = 0; i < 8; i++) begin
            var_ff[i] <= chain_ff[i];
         end
      end else if (cmd.round_en) begin
         var_ff[7] <= var_ff[6];
         var_ff[6] <= var_ff[5];
         var_ff[5] <= var_ff[4];
         var_ff[4] <= var_ff[3] + t1;
         var_ff[3] <= var_ff[2];
         var_ff[2] <= var_ff[1];
         var_ff[1] <= var_ff[0];
         var_ff[0] <= t1 + t2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.finish) begin
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= init_word(3'(i));
         end
      end else if (cmd.update_chain) begin
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= chain_ff[i] + var_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.finish) begin
         bitcnt_ff <= '0;
      end else if (cmd.count_en) begin
         bitcnt_ff <= bitcnt_ff + 64'd8;
      end else if (cmd.shift_en && cmd.shift_sel == SRC_LEN) begin
         bitcnt_ff <= {bitcnt_ff[55:0], 8'h00};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         out_ff <= {chain_ff[6], chain_ff[7], chain_ff[4], chain_ff[5],
                    chain_ff[2], chain_ff[3], chain_ff[0], chain_ff[1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign status.out_busy = out_valid_ff && !rsp_tready;
   assign rsp_tvalid      = out_valid_ff;
   assign rsp_tdata       = out_ff;

   // A new digest may only be loaded once the previous one has left.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!out_valid_ff || rsp_tready))
      else $error("digest overwritten before it was taken");

   // The datapath never shifts bytes in and runs a round in the same cycle.
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.shift_en && (cmd.round_en || cmd.update_chain)))
      else $error("byte shift during compression");

endmodule

`default_nettype wire

[sv/sha256_message_hasher_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Width  Contents
// req_     in   8+2    one message byte per word, byte flag in tuser, end mark in tlast
// rsp_     out  256    SHA-256 digest of a finished message, one word per message
//
// Message bytes are accepted while the controller is idle. The 64th byte of a
// block starts the round unit, which runs one round per cycle: the input then
// stalls for the 64 rounds and the chaining add. An end-marked word closes the
// message: padding and the length shift in one byte per cycle, with a pause in
// ST_PAD_ZERO before the length. Each padded block is compressed, and ST_FINISH
// then loads the digest once the output register is not busy.
// Reset is synchronous and returns the chaining words to the initial hash values.
// The digest sits in an output register; the next message may be fed while it
// waits; its successor holds in ST_FINISH, input stalled, until the first is taken.

module sha256_message_hasher_top
   import shamh_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output      logic         req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] data_byte
   input  wire logic         req_tuser,   // [0] byte_valid
   input  wire logic         req_tlast,   // end_of_message
   output      logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   // [63:0] digest_bits_255_192, [127:64] digest_bits_191_128,
   // [191:128] digest_bits_127_64, [255:192] digest_bits_63_0
   output      logic [255:0] rsp_tdata
);

   cmd_type    cmd;
   status_type status;

   // The controller sequences byte intake, padding, rounds and the digest hand-off.
   shamh_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .status     (status),
      .cmd        (cmd)
   );

   // The datapath holds the block buffer, the round unit and the chaining words.
   shamh_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

[bench/sha256_message_hasher_top_tb.sv]
`timescale 1ns / 1ps

module sha256_message_hasher_top_tb
   import shamh_pkg::*;
();

   // Once fewer words than this remain to be sent, both sides stop idling.
   localparam int TAIL_WORDS   = 250;
   // Words carrying a byte or an end mark that the random part aims for.
   localparam int TARGET_WORDS = 1950;
   // The receiver holds off this long once, after this many digests have arrived.
   localparam int HOLD_CYCLES  = 3000;
   localparam int HOLD_AFTER   = 4;
   // Cycles to wait after the last digest, enough for a padding pass and two
   // compressions.
   localparam int DRAIN_CYCLES = 300;

   // SHA-256 round constants and initial hash values.
   localparam logic [31:0] SHA_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
      32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
      32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
      32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
      32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
      32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
      32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
      32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
      32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };
   localparam logic [31:0] SHA_H0 [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   // One input word: a message byte, its valid flag and the end mark.
   typedef struct {
      logic [7:0] data;
      logic       has_byte;
      logic       is_last;
   } msg_word_type;

   // One digest, split the way the result word carries it.
   typedef struct {
      logic [63:0] bits_255_192;
      logic [63:0] bits_191_128;
      logic [63:0] bits_127_64;
      logic [63:0] bits_63_0;
   } digest_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = 8'h00;   // [7:0] data_byte
   logic         req_tuser = 1'b0;    // [0] byte_valid
   logic         req_tlast = 1'b0;    // end_of_message
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // [63:0] digest_bits_255_192, [127:64] digest_bits_191_128,
   // [191:128] digest_bits_127_64, [255:192] digest_bits_63_0
   logic [255:0] rsp_tdata;

   sha256_message_hasher_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Words still to be sent, and digests the hasher still owes us.
   msg_word_type pending_words[$];
   digest_type   digest_queue[$];

   int n_offered  = 0;     // words put on the bus by the driver
   int n_accepted = 0;     // words taken by the hasher
   int n_digests  = 0;     // digests taken from the hasher
   int n_errors   = 0;
   int n_counted  = 0;     // words with a byte or an end mark, idle words excluded
   bit stim_loaded = 1'b0;
   bit quiet_tail;

   assign quiet_tail = stim_loaded && (pending_words.size() < TAIL_WORDS);

   // ------------------------------------------------------------------------
   // Predictor state: chaining words, block buffer, fill position and the
   // running bit count of the message in progress.
   // ------------------------------------------------------------------------
   logic [31:0] hash_chain [8];
   logic [7:0]  msg_block  [64];
   logic [6:0]  msg_fill;
   logic [63:0] msg_bits;

   function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic restart_message();
      for (int i = 0; i < 8; i++) hash_chain[i] = SHA_H0[i];
      for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
      msg_fill = '0;
      msg_bits = '0;
   endtask

   // One compression of msg_block into hash_chain. The schedule is built in
   // full up front rather than in a rolling window.
   task automatic sha_compress();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2;
      for (int i = 0; i < 16; i++)
         w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
      for (int i = 16; i < 64; i++)
         w[i] = (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
              + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
      for (int i = 0; i < 8; i++) v[i] = hash_chain[i];
      for (int i = 0; i < 64; i++) begin
         t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[i] + w[i];
         t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6];
         v[6] = v[5];
         v[5] = v[4];
         v[4] = v[3] + t1;
         v[3] = v[2];
         v[2] = v[1];
         v[1] = v[0];
         v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_chain[i] = hash_chain[i] + v[i];
   endtask

   // Takes one accepted word. A byte joins the block and a full block is
   // compressed at once. The end mark pads the message, queues its digest and
   // starts a fresh message.
   task automatic hash_word(input msg_word_type wd);
      digest_type dg;
      if (wd.has_byte) begin
         msg_block[msg_fill[5:0]] = wd.data;
         msg_bits = msg_bits + 64'd8;
         msg_fill = msg_fill + 7'd1;
         if (msg_fill == 7'd64) begin
            sha_compress();
            msg_fill = '0;
         end
      end
      if (wd.is_last) begin
         msg_block[msg_fill[5:0]] = PAD_BYTE;
         msg_fill = msg_fill + 7'd1;
         // No room left for the length, so it gets a block of its own.
         if (msg_fill > 7'(FILL_LEN_POS)) begin
            for (int i = msg_fill; i < 64; i++) msg_block[i] = 8'h00;
            sha_compress();
            msg_fill = '0;
         end
         for (int i = msg_fill; i < 56; i++) msg_block[i] = 8'h00;
         for (int i = 0; i < 8; i++) msg_block[56+i] = 8'(msg_bits >> (56 - 8*i));
         sha_compress();
         dg.bits_255_192 = {hash_chain[0], hash_chain[1]};
         dg.bits_191_128 = {hash_chain[2], hash_chain[3]};
         dg.bits_127_64  = {hash_chain[4], hash_chain[5]};
         dg.bits_63_0    = {hash_chain[6], hash_chain[7]};
         digest_queue.push_back(dg);
         restart_message();
      end
   endtask

   // ------------------------------------------------------------------------
   // Stimulus helpers.
   // ------------------------------------------------------------------------
   task automatic queue_word(input logic [7:0] data, input logic has_byte,
                             input logic is_last);
      msg_word_type wd;
      wd.data     = data;
      wd.has_byte = has_byte;
      wd.is_last  = is_last;
      pending_words.push_back(wd);
      if (has_byte || is_last) n_counted++;
   endtask

   // A message of len random bytes with idle words sprinkled in. The end mark
   // rides on the last byte, or on a separate word without a byte whose data
   // the hasher must ignore.
   task automatic queue_message(input int len, input bit end_on_byte);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 11) == 0) queue_word(8'($urandom), 1'b0, 1'b0);
         queue_word(8'($urandom), 1'b1, (end_on_byte && i == len - 1) ? 1'b1 : 1'b0);
      end
      if (!end_on_byte || len == 0) queue_word(8'($urandom), 1'b0, 1'b1);
   endtask

   // Picks a message length: mostly short, sometimes right at the block and
   // padding boundaries, now and then empty or spanning a few blocks.
   function automatic int pick_length();
      int edges [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
      int len;
      case ($urandom_range(0, 9))
         6: len = edges[$urandom_range(0, 9)];
         7: len = 0;
         8: len = $urandom_range(100, 200);
         9: len = $urandom_range(1, 8);
         default: len = $urandom_range(1, 70);
      endcase
      return len;
   endfunction

   // ------------------------------------------------------------------------
   // Driver: offers the pending words, holding each until it is accepted, with
   // random idle bursts between words outside the tail of the run. Whether the
   // current word has been taken is read from the count kept at the rising edge.
   // ------------------------------------------------------------------------
   int req_gap = 0;

   always @(negedge clock) begin
      msg_word_type wd;
      logic         valid_next;
      if (!reset) begin
         valid_next = req_tvalid;
         if (!req_tvalid || n_accepted == n_offered) begin
            if (req_gap > 0) begin
               req_gap--;
               valid_next = 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
               req_gap = $urandom_range(1, 13) - 1;
               valid_next = 1'b0;
            end else if (pending_words.size() > 0) begin
               wd = pending_words.pop_front();
               req_tdata <= wd.data;
               req_tuser <= wd.has_byte;
               req_tlast <= wd.is_last;
               n_offered++;
               valid_next = 1'b1;
            end else begin
               valid_next = 1'b0;
            end
         end
         req_tvalid <= valid_next;
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: random stall bursts, plus one long hold-off while the driver
   // keeps sending, so that a digest waits in the output register, the next
   // message finishes behind it and the input has to stall.
   // ------------------------------------------------------------------------
   int  rsp_stall = 0;
   int  rsp_hold  = 0;
   bit  hold_done = 1'b0;

   always @(negedge clock) begin
      if (!reset) begin
         if (!hold_done && n_digests >= HOLD_AFTER) begin
            hold_done = 1'b1;
            rsp_hold  = HOLD_CYCLES;
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_tready <= 1'b0;
         end else if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            rsp_stall = $urandom_range(1, 13) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: at each rising edge, checks a digest handed over against the
   // oldest expectation, then feeds an accepted word to the predictor. A digest
   // never leaves on the edge that accepts the word ending its message.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      digest_type   dg;
      msg_word_type wd;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            n_digests <= n_digests + 1;
            if (digest_queue.size() == 0) begin
               $error("unexpected digest %h", rsp_tdata);
               n_errors++;
            end else begin
               dg = digest_queue.pop_front();
               if (rsp_tdata[63:0] !== dg.bits_255_192) begin
                  $error("digest_bits_255_192 expected %h actual %h",
                         dg.bits_255_192, rsp_tdata[63:0]);
                  n_errors++;
               end
               if (rsp_tdata[127:64] !== dg.bits_191_128) begin
                  $error("digest_bits_191_128 expected %h actual %h",
                         dg.bits_191_128, rsp_tdata[127:64]);
                  n_errors++;
               end
               if (rsp_tdata[191:128] !== dg.bits_127_64) begin
                  $error("digest_bits_127_64 expected %h actual %h",
                         dg.bits_127_64, rsp_tdata[191:128]);
                  n_errors++;
               end
               if (rsp_tdata[255:192] !== dg.bits_63_0) begin
                  $error("digest_bits_63_0 expected %h actual %h",
                         dg.bits_63_0, rsp_tdata[255:192]);
                  n_errors++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            wd.data     = req_tdata;
            wd.has_byte = req_tuser;
            wd.is_last  = req_tlast;
            hash_word(wd);
            n_accepted <= n_accepted + 1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence: load all stimulus, release reset, wait for the hasher to
   // take every word and return every digest, then report.
   // ------------------------------------------------------------------------
   initial begin
      restart_message();

      // Empty message on a fresh start, with the ignored data byte at all ones.
      queue_word(8'hff, 1'b0, 1'b1);
      // An idle word changes nothing, whatever its data.
      queue_word(8'hff, 1'b0, 1'b0);
      // Single-byte messages at both extremes of the byte.
      queue_word(8'h00, 1'b1, 1'b1);
      queue_word(8'hff, 1'b1, 1'b1);
      // "abc", closed by a separate end word that carries no byte.
      queue_word(8'h61, 1'b1, 1'b0);
      queue_word(8'h62, 1'b1, 1'b0);
      queue_word(8'h00, 1'b0, 1'b0);
      queue_word(8'h63, 1'b1, 1'b0);
      queue_word(8'h00, 1'b0, 1'b1);
      // Another empty message straight after one ended.
      queue_word(8'h00, 1'b0, 1'b1);
      // Two bytes, the end on the second.
      queue_word(8'h5a, 1'b1, 1'b0);
      queue_word(8'ha5, 1'b1, 1'b1);

      // Random messages, with an occasional idle word between them.
      while (n_counted < TARGET_WORDS) begin
         if ($urandom_range(0, 9) == 0) queue_word(8'($urandom), 1'b0, 1'b0);
         queue_message(pick_length(), 1'($urandom_range(0, 1)));
      end
      stim_loaded = 1'b1;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (pending_words.size() == 0 && n_accepted == n_offered);
      wait (digest_queue.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (n_errors == 0) begin
         $display("sha256_message_hasher_top_tb: PASS");
      end else begin
         $display("sha256_message_hasher_top_tb: FAIL");
      end
      $finish;
   end

   // Safety limit: several times the slowest correct run.
   initial begin
      #20ms;
      $display("sha256_message_hasher_top_tb: FAIL");
      $finish;
   end

endmodule
